### rtl/paged_framebuffer_dirty_refresh_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the paged frame buffer.
// Every property is sampled on clk and is held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PAGED_FRAMEBUFFER_DIRTY_REFRESH_ASSERT_SVH
`define PAGED_FRAMEBUFFER_DIRTY_REFRESH_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define PFDR_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// The condition holds in the cycle after the trigger.
`define PFDR_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

### rtl/pfdr_pkg.sv
// ---------------------------------------------------------------------------
// pfdr_pkg
// Shared types and constants of the paged frame buffer with dirty tracking.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfdr_pkg;

  // Default geometry.
  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;

  // Command codes.
  localparam logic [1:0] CMD_DRAW    = 2'd0;
  localparam logic [1:0] CMD_REFRESH = 2'd1;
  localparam logic [1:0] CMD_FILL    = 2'd2;

  // Draw modes.
  localparam logic [1:0] MODE_REPLACE = 2'd0;
  localparam logic [1:0] MODE_OR      = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_NO_DIRTY = 2'd2;

  // Panel command bytes.
  localparam logic [7:0] PANEL_PAGE_ADDR = 8'h22;
  localparam logic [7:0] PANEL_COL_ADDR  = 8'h21;
  localparam logic [7:0] PANEL_COL_END   = 8'h7f;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_DRD,
    S_DWR,
    S_MRD,
    S_MWR,
    S_SCRD,
    S_SCCHK,
    S_RUNRD,
    S_RUNCHK,
    S_XRD,
    S_XCHK,
    S_ANYRD,
    S_ANYCHK,
    S_PUT
  } pfdr_state_t;

  // Refresh stream phases.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEEK,
    PH_CMD,
    PH_DATA
  } pfdr_phase_t;

endpackage

`default_nettype wire

### rtl/pfdr_if.sv
// ---------------------------------------------------------------------------
// pfdr channel interfaces
// Valid/ready channels for command words and result words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pfdr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  column;
  logic [7:0]  top_row;
  logic [6:0]  run_length;
  logic [63:0] pixel_bits;
  logic [1:0]  draw_mode;

  modport source (output valid, command, column, top_row, run_length, pixel_bits,
                  draw_mode, input ready);
  modport sink (input valid, command, column, top_row, run_length, pixel_bits,
                draw_mode, output ready);
endinterface

interface pfdr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       is_data;
  logic [7:0] panel_byte;
  logic       refresh_done;

  modport source (output valid, status, is_data, panel_byte, refresh_done, input ready);
  modport sink (input valid, status, is_data, panel_byte, refresh_done, output ready);
endinterface

`default_nettype wire

### rtl/pfdr_ram.sv
// ---------------------------------------------------------------------------
// pfdr_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### rtl/paged_framebuffer_dirty_refresh.sv
// ---------------------------------------------------------------------------
// paged_framebuffer_dirty_refresh
// One-bit-per-pixel paged frame store with per-column dirty masks and a
// byte-wise panel refresh stream.
// ---------------------------------------------------------------------------
//  channel  dir  handshake          word
//  in_ch    in   valid/ready        command, column, top_row, run_length,
//                                   pixel_bits, draw_mode
//  out_ch   out  valid/ready        status, is_data, panel_byte, refresh_done
//
// One word is processed at a time; the frame store and dirty masks are
// one-port-read, one-port-write RAMs. A draw reads and rewrites each page
// byte, then the column's dirty mask. A refresh word returns at most one
// header or data byte; after a run's last data byte the following columns
// are scanned for dirt. After reset a clearing pass runs before in_ch.ready.
// A result waits in the output register while the next word is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module paged_framebuffer_dirty_refresh #(
  parameter int COLUMNS = pfdr_pkg::COLUMNS_DEF,
  parameter int PAGES   = pfdr_pkg::PAGES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pfdr_in_if.sink   in_ch,
  pfdr_out_if.source out_ch
);

  import pfdr_pkg::*;

  `include "paged_framebuffer_dirty_refresh_assert.svh"

  localparam int CW = $clog2(COLUMNS);
  localparam int AW = CW + 3;
  localparam logic [7:0]    PM       = 8'((1 << PAGES) - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [AW-1:0] ADR_LAST = AW'(COLUMNS * 8 - 1);
  localparam logic [2:0]    PG_LAST  = 3'(PAGES - 1);
  localparam logic [8:0]    COL_LIM  = 9'(COLUMNS);
  localparam logic [8:0]    ROW_LIM  = 9'(PAGES * 8);

  // Lowest set bit of a page mask.
  function automatic logic [2:0] low_bit(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  // Highest set bit of a page mask.
  function automatic logic [2:0] high_bit(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  pfdr_state_t state_r, state_nxt;
  pfdr_phase_t phase_r, phase_nxt;
  logic [2:0]    cmdk_r, cmdk_nxt;
  logic [CW-1:0] first_r, first_nxt;
  logic [CW-1:0] last_r, last_nxt;
  logic [2:0]    up_r, up_nxt;
  logic [2:0]    down_r, down_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [2:0]    cur_pg_r, cur_pg_nxt;
  logic [CW-1:0] scol_r, scol_nxt;
  logic [7:0]    all_r, all_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic [7:0]    fillb_r, fillb_nxt;
  logic          sweep_put_r, sweep_put_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [2:0]    page_r, page_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [63:0]   m_r, m_nxt;
  logic [63:0]   d_r, d_nxt;
  logic [7:0]    dacc_r, dacc_nxt;
  logic [1:0]    res_st_r, res_st_nxt;
  logic          res_data_r, res_data_nxt;
  logic [7:0]    res_byte_r, res_byte_nxt;
  logic          res_done_r, res_done_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_st_r, out_st_nxt;
  logic          out_data_r, out_data_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_done_r, out_done_nxt;

  logic          fs_we;
  logic [AW-1:0] fs_waddr, fs_raddr;
  logic [7:0]    fs_wdata, fs_rdata;
  logic          dm_we;
  logic [CW-1:0] dm_waddr, dm_raddr;
  logic [7:0]    dm_wdata, dm_rdata;

  logic [63:0] runmask;
  logic [7:0]  old_b, nv_b, bm, bd;
  logic        run_end;

  // Frame store, addressed as column and page.
  pfdr_ram #(.WIDTH(8), .DEPTH(COLUMNS * 8)) u_store (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(fs_raddr), .rdata(fs_rdata)
  );

  // Dirty masks, one word per column.
  pfdr_ram #(.WIDTH(8), .DEPTH(COLUMNS)) u_dirty (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .raddr(dm_raddr), .rdata(dm_rdata)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.is_data      = out_data_r;
  assign out_ch.panel_byte   = out_byte_r;
  assign out_ch.refresh_done = out_done_r;

  // Run mask of the draw, before it is moved to the top row.
  assign runmask = in_ch.run_length[6] ? '1 :
                   ((64'd1 << in_ch.run_length[5:0]) - 64'd1);

  // Read-modify-write of one page byte in a draw.
  always_comb begin
    old_b = fs_rdata;
    bm    = m_r[7:0];
    bd    = d_r[7:0];
    case (mode_r)
      MODE_REPLACE: nv_b = (old_b & ~bm) | bd;
      MODE_OR:      nv_b = old_b | bd;
      MODE_CLEAR:   nv_b = old_b & ~bd;
      default:      nv_b = old_b;
    endcase
  end

  // Sequencer: next state, memory ports and result.
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cmdk_nxt      = cmdk_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    up_nxt        = up_r;
    down_nxt      = down_r;
    cur_col_nxt   = cur_col_r;
    cur_pg_nxt    = cur_pg_r;
    scol_nxt      = scol_r;
    all_nxt       = all_r;
    sweep_nxt     = sweep_r;
    fillb_nxt     = fillb_r;
    sweep_put_nxt = sweep_put_r;
    col_nxt       = col_r;
    page_nxt      = page_r;
    mode_nxt      = mode_r;
    m_nxt         = m_r;
    d_nxt         = d_r;
    dacc_nxt      = dacc_r;
    res_st_nxt    = res_st_r;
    res_data_nxt  = res_data_r;
    res_byte_nxt  = res_byte_r;
    res_done_nxt  = res_done_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_st_nxt    = out_st_r;
    out_data_nxt  = out_data_r;
    out_byte_nxt  = out_byte_r;
    out_done_nxt  = out_done_r;
    fs_we    = 1'b0;
    fs_waddr = {col_r, page_r};
    fs_wdata = nv_b;
    fs_raddr = {col_r, page_r};
    dm_we    = 1'b0;
    dm_waddr = scol_r;
    dm_wdata = 8'd0;
    dm_raddr = scol_r;
    run_end  = 1'b0;

    unique case (state_r)
      // Clearing pass after reset and fill sweep.
      S_SWEEP: begin
        fs_we    = 1'b1;
        fs_waddr = sweep_r;
        fs_wdata = fillb_r;
        if (sweep_r[2:0] == 3'd0) begin
          dm_we    = 1'b1;
          dm_waddr = sweep_r[AW-1:3];
        end
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == ADR_LAST) begin
          state_nxt = sweep_put_r ? S_PUT : S_IDLE;
        end
      end

      // Take a command word.
      S_IDLE: begin
        if (in_ch.valid) begin
          res_st_nxt   = ST_OK;
          res_data_nxt = 1'b0;
          res_byte_nxt = 8'd0;
          res_done_nxt = 1'b0;
          state_nxt    = S_PUT;
          case (in_ch.command)
            CMD_DRAW: begin
              if (({1'b0, in_ch.column} >= COL_LIM) ||
                  (({1'b0, in_ch.top_row} + {2'b00, in_ch.run_length}) > ROW_LIM)) begin
                res_st_nxt = ST_RANGE;
              end else if (in_ch.run_length != 7'd0) begin
                col_nxt   = in_ch.column[CW-1:0];
                page_nxt  = 3'd0;
                mode_nxt  = in_ch.draw_mode;
                m_nxt     = runmask << in_ch.top_row[5:0];
                d_nxt     = (in_ch.pixel_bits & runmask) << in_ch.top_row[5:0];
                dacc_nxt  = 8'd0;
                state_nxt = S_DRD;
              end
            end
            CMD_REFRESH: begin
              unique case (phase_r)
                PH_IDLE: begin
                  scol_nxt  = '0;
                  state_nxt = S_SCRD;
                end
                PH_SEEK: begin
                  scol_nxt  = first_r;
                  state_nxt = S_SCRD;
                end
                PH_CMD: begin
                  cmdk_nxt = cmdk_r + 3'd1;
                  case (cmdk_r)
                    3'd0:    res_byte_nxt = {5'd0, up_r};
                    3'd1:    res_byte_nxt = {5'd0, down_r};
                    3'd2:    res_byte_nxt = PANEL_COL_ADDR;
                    3'd3:    res_byte_nxt = 8'(first_r);
                    default: begin
                      res_byte_nxt = PANEL_COL_END;
                      phase_nxt    = PH_DATA;
                    end
                  endcase
                end
                PH_DATA: begin
                  state_nxt = S_XRD;
                end
                default: ;
              endcase
            end
            CMD_FILL: begin
              fillb_nxt     = in_ch.pixel_bits[7:0];
              sweep_nxt     = '0;
              sweep_put_nxt = 1'b1;
              state_nxt     = S_SWEEP;
            end
            default: ;
          endcase
        end
      end

      // Draw: each page byte is read, then written back.
      S_DRD: begin
        state_nxt = S_DWR;
      end
      S_DWR: begin
        fs_we = 1'b1;
        if (nv_b != old_b) begin
          dacc_nxt = dacc_r | (8'd1 << page_r);
        end
        m_nxt = m_r >> 8;
        d_nxt = d_r >> 8;
        if (page_r == PG_LAST) begin
          state_nxt = S_MRD;
        end else begin
          page_nxt  = page_r + 3'd1;
          state_nxt = S_DRD;
        end
      end
      S_MRD: begin
        dm_raddr  = col_r;
        state_nxt = S_MWR;
      end
      S_MWR: begin
        dm_we     = 1'b1;
        dm_waddr  = col_r;
        dm_wdata  = dm_rdata | dacc_r;
        state_nxt = S_PUT;
      end

      // Search for the first dirty column of a run.
      S_SCRD: begin
        state_nxt = S_SCCHK;
      end
      S_SCCHK: begin
        if ((dm_rdata & PM) != 8'd0) begin
          dm_we     = 1'b1;
          all_nxt   = dm_rdata & PM;
          first_nxt = scol_r;
          last_nxt  = scol_r;
          state_nxt = S_RUNRD;
        end else if (scol_r == COL_LAST) begin
          phase_nxt  = PH_IDLE;
          res_st_nxt = ST_NO_DIRTY;
          state_nxt  = S_PUT;
        end else begin
          scol_nxt  = scol_r + CW'(1);
          state_nxt = S_SCRD;
        end
      end

      // Extend the run and clear its masks.
      S_RUNRD: begin
        dm_raddr = last_r + CW'(1);
        if (last_r == COL_LAST) begin
          run_end = 1'b1;
        end else begin
          state_nxt = S_RUNCHK;
        end
      end
      S_RUNCHK: begin
        if ((dm_rdata & PM) != 8'd0) begin
          dm_we     = 1'b1;
          dm_waddr  = last_r + CW'(1);
          all_nxt   = all_r | (dm_rdata & PM);
          last_nxt  = last_r + CW'(1);
          state_nxt = S_RUNRD;
        end else begin
          run_end = 1'b1;
        end
      end

      // Data byte of the run.
      S_XRD: begin
        fs_raddr  = {cur_col_r, cur_pg_r};
        state_nxt = S_XCHK;
      end
      S_XCHK: begin
        res_data_nxt = 1'b1;
        res_byte_nxt = fs_rdata;
        state_nxt    = S_PUT;
        if (cur_pg_r < down_r) begin
          cur_pg_nxt = cur_pg_r + 3'd1;
        end else if (cur_col_r < last_r) begin
          cur_col_nxt = cur_col_r + CW'(1);
          cur_pg_nxt  = up_r;
        end else if (cur_col_r == COL_LAST) begin
          phase_nxt    = PH_IDLE;
          res_done_nxt = 1'b1;
        end else begin
          first_nxt = cur_col_r + CW'(1);
          scol_nxt  = cur_col_r + CW'(1);
          state_nxt = S_ANYRD;
        end
      end

      // Is any column after the run still dirty?
      S_ANYRD: begin
        state_nxt = S_ANYCHK;
      end
      S_ANYCHK: begin
        if ((dm_rdata & PM) != 8'd0) begin
          phase_nxt = PH_SEEK;
          state_nxt = S_PUT;
        end else if (scol_r == COL_LAST) begin
          phase_nxt    = PH_IDLE;
          res_done_nxt = 1'b1;
          state_nxt    = S_PUT;
        end else begin
          scol_nxt  = scol_r + CW'(1);
          state_nxt = S_ANYRD;
        end
      end

      // Hand the result to the output register.
      S_PUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_data_nxt  = res_data_r;
          out_byte_nxt  = res_byte_r;
          out_done_nxt  = res_done_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Run found: latch window and start the command bytes.
    if (run_end) begin
      up_nxt       = low_bit(all_r);
      down_nxt     = high_bit(all_r);
      cur_col_nxt  = first_r;
      cur_pg_nxt   = low_bit(all_r);
      cmdk_nxt     = 3'd0;
      phase_nxt    = PH_CMD;
      res_byte_nxt = PANEL_PAGE_ADDR;
      state_nxt    = S_PUT;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      phase_r     <= PH_IDLE;
      cmdk_r      <= 3'd0;
      first_r     <= '0;
      last_r      <= '0;
      up_r        <= 3'd0;
      down_r      <= 3'd0;
      cur_col_r   <= '0;
      cur_pg_r    <= 3'd0;
      scol_r      <= '0;
      sweep_r     <= '0;
      fillb_r     <= 8'd0;
      sweep_put_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cmdk_r      <= cmdk_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      up_r        <= up_nxt;
      down_r      <= down_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_pg_r    <= cur_pg_nxt;
      scol_r      <= scol_nxt;
      sweep_r     <= sweep_nxt;
      fillb_r     <= fillb_nxt;
      sweep_put_r <= sweep_put_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    all_r      <= all_nxt;
    col_r      <= col_nxt;
    page_r     <= page_nxt;
    mode_r     <= mode_nxt;
    m_r        <= m_nxt;
    d_r        <= d_nxt;
    dacc_r     <= dacc_nxt;
    res_st_r   <= res_st_nxt;
    res_data_r <= res_data_nxt;
    res_byte_r <= res_byte_nxt;
    res_done_r <= res_done_nxt;
    out_st_r   <= out_st_nxt;
    out_data_r <= out_data_nxt;
    out_byte_r <= out_byte_nxt;
    out_done_r <= out_done_nxt;
  end

  // A new word appears only from the result hand-off state.
  `PFDR_ASSERT_NEXT(a_out_from_put, (out_valid_r || state_r != S_PUT) && !out_valid_r && state_r != S_PUT, !out_valid_r, "result word without hand-off")
  // Command byte counter stays within the six-byte header.
  `PFDR_ASSERT_NOW(a_cmd_count, phase_r == PH_CMD, cmdk_r <= 3'd4, "command byte counter overrun")
  // Data cursor stays inside the page window of the run.
  `PFDR_ASSERT_NOW(a_cursor_window, phase_r == PH_DATA, (cur_pg_r >= up_r) && (cur_pg_r <= down_r) && (cur_col_r <= last_r), "data cursor outside run window")

endmodule

`default_nettype wire
